### rtl/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0] START_BYTE_RESET = 8'h1A;
  localparam logic [7:0] CRC_INIT         = 8'hFF;
  localparam logic [7:0] CRC_POLY         = 8'h31;

  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_DATA   = 2'd1,
    EV_GOOD   = 2'd2,
    EV_CRCERR = 2'd3
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] value;
    logic [7:0] index;
    logic       aborted;
  } sfd_res_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/sfd_core.sv
module sfd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output sfd_pkg::sfd_res_t res
);
  import sfd_pkg::*;

  logic [7:0] start_byte;
  logic       escape_pending, escape_pending_next;
  logic       in_frame, in_frame_next;
  logic [8:0] frame_position, frame_position_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] running_crc, running_crc_next;

  logic       process;
  logic       opens;
  logic       frame_eff;
  logic [8:0] pos_eff;
  logic [7:0] crc_eff;
  logic [8:0] data_idx;
  logic       advance;

  always_comb begin
    escape_pending_next = escape_pending;
    in_frame_next       = in_frame;
    frame_position_next = frame_position;
    payload_length_next = payload_length;
    running_crc_next    = running_crc;
    res_valid           = 1'b0;
    res                 = '0;
    process             = 1'b0;
    opens               = 1'b0;
    advance             = 1'b0;

    // An escaped byte either is a literal start byte or opens a new frame.
    if (escape_pending) begin
      process = 1'b1;
      opens   = (in_byte != start_byte);
    end else if (in_byte != start_byte) begin
      process = 1'b1;
    end

    frame_eff = in_frame | opens;
    pos_eff   = opens ? 9'd0 : frame_position;
    crc_eff   = opens ? CRC_INIT : running_crc;
    data_idx  = pos_eff - 9'd1;

    if (in_valid) begin
      escape_pending_next = !escape_pending && (in_byte == start_byte);
      if (process && frame_eff) begin
        in_frame_next       = 1'b1;
        frame_position_next = pos_eff;
        running_crc_next    = crc_eff;
        res_valid           = 1'b1;
        if (pos_eff == 9'd0) begin
          payload_length_next = (in_byte > start_byte) ? in_byte - 8'd1 : in_byte;
          res.ev      = EV_START;
          res.value   = payload_length_next;
          res.aborted = opens & in_frame;
          advance     = 1'b1;
        end else if (data_idx < {1'b0, payload_length}) begin
          res.ev    = EV_DATA;
          res.value = in_byte;
          res.index = data_idx[7:0];
          advance   = 1'b1;
        end else if (data_idx == {1'b0, payload_length} && crc_eff == in_byte) begin
          res.ev        = EV_GOOD;
          in_frame_next = 1'b0;
          advance       = 1'b1;
        end else begin
          res.ev        = EV_CRCERR;
          in_frame_next = 1'b0;
        end
        if (advance) begin
          frame_position_next = pos_eff + 9'd1;
          running_crc_next    = crc8_step(crc_eff, in_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RESET;
      escape_pending <= 1'b0;
      in_frame       <= 1'b0;
      frame_position <= '0;
      payload_length <= '0;
      running_crc    <= CRC_INIT;
    end else begin
      if (cfg_we) begin
        start_byte <= cfg_wdata;
      end
      escape_pending <= escape_pending_next;
      in_frame       <= in_frame_next;
      frame_position <= frame_position_next;
      payload_length <= payload_length_next;
      running_crc    <= running_crc_next;
    end
  end

endmodule

### rtl/sfd_out_buf.sv
module sfd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfd_pkg::sfd_res_t push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sfd_pkg::sfd_res_t out_data
);
  import sfd_pkg::*;

  logic     skid_valid;
  sfd_res_t skid_data;

  assign in_ready = !skid_valid;

  // The skid stage catches a word that arrives while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= push_data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

### rtl/stuffed_frame_deframer_crc8.sv
// Byte-stuffed frame receiver with CRC-8 check. Each raw link byte on the
// slave stream is unstuffed and tracked through the frame combinationally,
// so one byte is taken every clock. The only limit is the registered output
// with its one-word skid stage: a result that arrives while the master side
// stalls with a word waiting goes to the skid stage, and s_tready stays low
// up to and including the edge at which the master side takes the waiting
// word. A byte yields at most one result word: frame start (with payload
// length and an abort flag), data byte with its index, frame good, or CRC
// error. Escape and lone start bytes give no word. The start byte is set
// through cfg_we/cfg_wdata by the user only while idle, unchecked by the block.
module stuffed_frame_deframer_crc8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] value, [15:8] index, [16] aborted_previous
  output logic [1:0]  m_tuser    // [1:0] event_res
);
  import sfd_pkg::*;

  logic     in_accept;
  logic     res_valid;
  sfd_res_t res;
  sfd_res_t out_data;

  assign in_accept = s_tvalid & s_tready;

  sfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_accept),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {7'd0, out_data.aborted, out_data.index, out_data.value};
  assign m_tuser = out_data.ev;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no output word waiting");

  a_close_no_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == EV_GOOD || m_tuser == EV_CRCERR)) |-> (m_tdata == 24'd0))
    else $error("frame close word carries payload");

  a_abort_only_start: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != EV_START) |-> !m_tdata[16])
    else $error("abort flag on a word that is not a frame start");

endmodule
